>>> design/windowed_pulse_interval_averager_defines.svh
// Assertion macros used by the checker file.
`ifndef WINDOWED_PULSE_INTERVAL_AVERAGER_DEFINES_SVH
`define WINDOWED_PULSE_INTERVAL_AVERAGER_DEFINES_SVH

// Condition in one cycle implies an expression in the next, outside reset.
`define WPIA_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
        else $error("wpia: next-cycle check failed");

// Reset held in one cycle implies an expression in the next.
`define WPIA_ASSERT_RST(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) !(rst_n) |=> (expr)) \
        else $error("wpia: reset check failed");

`endif

>>> design/wpia_pkg.sv
package wpia_pkg;

    localparam int WPIA_WINDOW_FRAMES = 10;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_INTERVAL = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDLE_TIMEOUT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_TICKS  = 2'd2;

    localparam logic [15:0] MIN_INTERVAL_RESET = 16'd250;
    localparam logic [7:0]  IDLE_TIMEOUT_RESET = 8'd50;
    localparam logic [7:0]  FRAME_TICKS_RESET  = 8'd10;
    localparam logic [15:0] EMPTY_MEAN         = 16'hFFFF;

    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = 5;

    typedef struct packed {
        logic        kind;
        logic [15:0] capture_time;
    } t_in_item;

    typedef struct packed {
        logic [15:0] mean_interval;
        logic [31:0] pulse_total;
    } t_out_item;

    typedef struct packed {
        logic [31:0] sum;
        logic [15:0] count;
    } t_frame;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_SUM,
        S_LAST,
        S_DIV_GO,
        S_DIV_WAIT,
        S_DONE
    } t_state;

endpackage

>>> design/wpia_div.sv
module wpia_div
    import wpia_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_done,
    output logic [15:0] o_quotient
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [15:0]          r_rem;
    logic [31:0]          r_quo;
    logic [15:0]          r_div;

    logic [16:0] shifted;
    logic [16:0] diff;
    logic        ge;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb begin
        shifted = {r_rem, r_quo[31]};
        diff    = shifted - {1'b0, r_div};
        ge      = shifted >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[15:0] : shifted[15:0];
            r_quo <= {r_quo[30:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo[15:0];

endmodule

>>> design/windowed_pulse_interval_averager.sv
// Period-measurement tachometer. Each request is a sensor edge with a 16-bit
// capture time or a base tick; each returns one result with the mean interval
// over a ring of WINDOW_FRAMES frames (65535 when the window is empty) and the
// edge total. Requests are handled one at a time: the next request is taken
// only once the sweep over the frame memory, one entry per cycle, and the
// 32-step serial divider have finished with the last one.
// A finished result waits in the output register while the next request is
// taken. Configuration writes land at once and are meant for idle periods.
module windowed_pulse_interval_averager
    import wpia_pkg::*;
#(
    parameter int WINDOW_FRAMES = WPIA_WINDOW_FRAMES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int IDX_W = (WINDOW_FRAMES > 1) ? $clog2(WINDOW_FRAMES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_FRAMES - 1);

    t_state r_state;
    t_state n_state;

    // configuration
    logic [15:0] r_min_interval;
    logic [7:0]  r_idle_timeout;
    logic [7:0]  r_frame_ticks;

    // scalar state
    logic [IDX_W-1:0]         r_frame_index;
    logic [15:0]              r_last_capture;
    logic                     r_last_valid;
    logic [7:0]               r_idle_count;
    logic [7:0]               r_tick_in_frame;
    logic [31:0]              r_pulse_count;
    logic [WINDOW_FRAMES-1:0] r_vld;

    // frame memory
    t_frame           r_mem [WINDOW_FRAMES];
    t_frame           r_rd_data;
    logic             r_rd_ok;
    logic [IDX_W-1:0] rd_addr;

    t_in_item         r_item;
    logic [IDX_W-1:0] r_idx;
    logic             r_acc_en;
    logic [31:0]      r_wsum;
    logic [15:0]      r_wcnt;

    logic             r_out_valid;
    t_out_item        r_out_data;

    // FSM outputs
    logic in_ready;
    logic do_mod;
    logic sweep;
    logic div_start;
    logic out_load;

    logic             div_done;
    logic [15:0]      div_quo;

    logic             in_fire;
    logic             is_edge;
    t_frame           cur;
    t_frame           n_entry;
    logic [15:0]      delta;
    logic             accumulate;
    logic [7:0]       idle_inc;
    logic [7:0]       tick_inc;
    logic             timeout;
    logic             advance;
    logic [IDX_W-1:0] next_index;

    assign in_fire = i_in_valid && in_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (in_fire) n_state = S_MOD;
            S_MOD:      n_state = S_SUM;
            S_SUM:      if (r_idx == LAST_IDX) n_state = S_LAST;
            S_LAST:     n_state = S_DIV_GO;
            S_DIV_GO:   n_state = S_DIV_WAIT;
            S_DIV_WAIT: if (div_done) n_state = S_DONE;
            S_DONE:     if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        in_ready  = 1'b0;
        do_mod    = 1'b0;
        sweep     = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            S_IDLE:     in_ready  = 1'b1;
            S_MOD:      do_mod    = 1'b1;
            S_SUM:      sweep     = 1'b1;
            S_LAST:     ;
            S_DIV_GO:   div_start = 1'b1;
            S_DIV_WAIT: ;
            S_DONE:     out_load  = !r_out_valid || i_out_ready;
            default:    ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_interval <= MIN_INTERVAL_RESET;
            r_idle_timeout <= IDLE_TIMEOUT_RESET;
            r_frame_ticks  <= FRAME_TICKS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_MIN_INTERVAL: r_min_interval <= i_cfg_wdata;
                CFG_IDLE_TIMEOUT: r_idle_timeout <= i_cfg_wdata[7:0];
                CFG_FRAME_TICKS:  r_frame_ticks  <= i_cfg_wdata[7:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item <= i_in_data;
        end
    end

    // update of the current frame and the scalar state
    always_comb begin
        is_edge    = r_item.kind == KIND_EDGE;
        cur        = r_rd_ok ? r_rd_data : '0;
        delta      = r_item.capture_time - r_last_capture;
        accumulate = is_edge && r_last_valid && (delta >= r_min_interval);
        n_entry.sum   = cur.sum + {16'd0, delta};
        n_entry.count = cur.count + 16'd1;
        idle_inc   = r_idle_count + 8'd1;
        tick_inc   = r_tick_in_frame + 8'd1;
        timeout    = idle_inc >= r_idle_timeout;
        advance    = tick_inc >= r_frame_ticks;
        next_index = (r_frame_index == LAST_IDX) ? '0 : r_frame_index + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_index   <= '0;
            r_last_capture  <= '0;
            r_last_valid    <= 1'b0;
            r_idle_count    <= '0;
            r_tick_in_frame <= '0;
            r_pulse_count   <= '0;
            r_vld           <= '0;
        end else if (do_mod) begin
            if (is_edge) begin
                r_last_valid   <= !(r_last_valid && (delta < r_min_interval));
                r_last_capture <= r_item.capture_time;
                r_idle_count   <= '0;
                r_pulse_count  <= r_pulse_count + 32'd1;
                if (accumulate) begin
                    r_vld[r_frame_index] <= 1'b1;
                end
            end else begin
                r_idle_count    <= timeout ? 8'd0 : idle_inc;
                r_tick_in_frame <= advance ? 8'd0 : tick_inc;
                if (timeout) begin
                    r_last_valid <= 1'b0;
                end
                if (advance) begin
                    r_frame_index <= next_index;
                end
                // drop the whole window on timeout, the entered frame on advance
                r_vld <= (timeout ? '0 : r_vld)
                       & ~(advance ? (WINDOW_FRAMES'(1) << next_index) : '0);
            end
        end
    end

    // frame memory: one write port, one registered read port
    assign rd_addr = sweep ? r_idx : r_frame_index;

    always_ff @(posedge i_clk) begin
        if (do_mod && accumulate) begin
            r_mem[r_frame_index] <= n_entry;
        end
        r_rd_data <= r_mem[rd_addr];
        r_rd_ok   <= r_vld[rd_addr];
    end

    // sweep the window and total it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_acc_en <= 1'b0;
        end else begin
            r_acc_en <= sweep;
            if (do_mod) begin
                r_idx <= '0;
            end else if (sweep) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_mod) begin
            r_wsum <= '0;
            r_wcnt <= '0;
        end else if (r_acc_en && r_rd_ok) begin
            r_wsum <= r_wsum + r_rd_data.sum;
            r_wcnt <= r_wcnt + r_rd_data.count;
        end
    end

    wpia_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_wsum),
        .i_divisor  (r_wcnt),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // output register: hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data.mean_interval <= (r_wcnt == 16'd0) ? EMPTY_MEAN : div_quo;
            r_out_data.pulse_total   <= r_pulse_count;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> design/wpia_checker.sv
`include "windowed_pulse_interval_averager_defines.svh"

module wpia_checker
    import wpia_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // one request in flight: ready drops right after an accept
    `WPIA_ASSERT_NEXT(a_single_request, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    `WPIA_ASSERT_NEXT(a_result_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

    // reset leaves the block empty and ready for a request
    `WPIA_ASSERT_RST(a_reset_state, i_clk, i_rst_n, !o_out_valid && o_in_ready)

endmodule

bind windowed_pulse_interval_averager wpia_checker u_wpia_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import wpia_pkg::*;

    localparam int CYCLE_LIMIT  = 4000000;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_SETTLE   = 120;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int REPORT_CAP   = 40;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in_item              in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    windowed_pulse_interval_averager i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_addr (cfg_addr),
        .i_cfg_wdata(cfg_wdata)
    );

    always #5 clk = ~clk;

    // Tachometer mirror: registers and window state.
    logic [15:0] cfg_min;
    logic [7:0]  cfg_timeout;
    logic [7:0]  cfg_frame_ticks;
    logic [31:0] win_sums [WPIA_WINDOW_FRAMES];
    logic [15:0] win_counts [WPIA_WINDOW_FRAMES];
    logic [3:0]  win_frame;
    logic [15:0] last_stamp;
    logic        last_stamp_ok;
    logic [7:0]  idle_ticks;
    logic [7:0]  frame_tick_cnt;
    logic [31:0] edge_total;

    t_out_item   expected_readings[$];

    int cycle_count = 0;
    int mismatch_count = 0;
    int requests_sent = 0;
    int readings_seen = 0;
    int settings_applied = 0;
    int timeout_clears = 0;
    int ring_advances = 0;
    int glitches_rejected = 0;

    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    logic [7:0] hold_req = '0;
    logic [7:0] hold_ack = '0;
    int rx_hold_left = 0;
    int rx_stall_left = 0;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(30, 150);
    endfunction

    task automatic reset_tachometer();
        int i;
        cfg_min         = MIN_INTERVAL_RESET;
        cfg_timeout     = IDLE_TIMEOUT_RESET;
        cfg_frame_ticks = FRAME_TICKS_RESET;
        for (i = 0; i < WPIA_WINDOW_FRAMES; i++) begin
            win_sums[i]   = '0;
            win_counts[i] = '0;
        end
        win_frame      = '0;
        last_stamp     = '0;
        last_stamp_ok  = 1'b0;
        idle_ticks     = '0;
        frame_tick_cnt = '0;
        edge_total     = '0;
    endtask

    function automatic t_out_item predict_reading(input t_in_item item);
        int          i;
        logic [15:0] delta;
        logic [31:0] sum;
        logic [15:0] cnt;
        logic [31:0] quotient;
        logic [3:0]  next_frame;
        t_out_item   r;
        if (item.kind == KIND_EDGE) begin
            if (last_stamp_ok) begin
                delta = item.capture_time - last_stamp;
                if (delta < cfg_min) begin
                    last_stamp_ok = 1'b0;
                    glitches_rejected++;
                end else begin
                    win_counts[win_frame] = win_counts[win_frame] + 16'd1;
                    win_sums[win_frame]   = win_sums[win_frame] + {16'd0, delta};
                end
            end else begin
                last_stamp_ok = 1'b1;
            end
            last_stamp = item.capture_time;
            idle_ticks = '0;
            edge_total = edge_total + 32'd1;
        end else begin
            idle_ticks = idle_ticks + 8'd1;
            if (idle_ticks >= cfg_timeout) begin
                idle_ticks = '0;
                for (i = 0; i < WPIA_WINDOW_FRAMES; i++) begin
                    win_sums[i]   = '0;
                    win_counts[i] = '0;
                end
                last_stamp_ok = 1'b0;
                timeout_clears++;
            end
            frame_tick_cnt = frame_tick_cnt + 8'd1;
            if (frame_tick_cnt >= cfg_frame_ticks) begin
                frame_tick_cnt = '0;
                next_frame = (win_frame == WPIA_WINDOW_FRAMES - 1) ? 4'd0 : win_frame + 4'd1;
                win_frame = next_frame;
                win_sums[next_frame]   = '0;
                win_counts[next_frame] = '0;
                ring_advances++;
            end
        end
        sum = '0;
        cnt = '0;
        for (i = 0; i < WPIA_WINDOW_FRAMES; i++) begin
            sum = sum + win_sums[i];
            cnt = cnt + win_counts[i];
        end
        if (cnt == 16'd0) begin
            r.mean_interval = EMPTY_MEAN;
        end else begin
            quotient = sum / {16'd0, cnt};
            r.mean_interval = quotient[15:0];
        end
        r.pulse_total = edge_total;
        return r;
    endfunction

    function automatic t_in_item edge_at(input logic [15:0] stamp);
        t_in_item item;
        item.kind = KIND_EDGE;
        item.capture_time = stamp;
        return item;
    endfunction

    // Capture time is random on ticks: the block must ignore it.
    function automatic t_in_item tick_item();
        t_in_item item;
        item.kind = KIND_TICK;
        item.capture_time = 16'($urandom);
        return item;
    endfunction

    task automatic send_request(input t_in_item item);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expected_readings.push_back(predict_reading(item));
        requests_sent++;
    endtask

    task automatic wait_for_readings();
        in_valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        case (addr)
            CFG_MIN_INTERVAL: cfg_min         = data;
            CFG_IDLE_TIMEOUT: cfg_timeout     = data[7:0];
            CFG_FRAME_TICKS:  cfg_frame_ticks = data[7:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Upper bits of the 8-bit registers carry junk that must be masked.
    task automatic program_registers(input logic [15:0] min_val,
                                     input logic [7:0] timeout_val,
                                     input logic [7:0] frame_val);
        wait_for_readings();
        cfg_write(CFG_MIN_INTERVAL, min_val);
        cfg_write(CFG_IDLE_TIMEOUT, {8'($urandom), timeout_val});
        cfg_write(CFG_FRAME_TICKS, {8'($urandom), frame_val});
        settings_applied++;
    endtask

    // Rotating sensor bursts with glitches, noise and idle tick runs.
    task automatic random_traffic(input int n_items);
        int          sent;
        int          burst;
        int          period;
        int          jitter;
        int          choice;
        int          k;
        int          run;
        logic [15:0] stamp;
        stamp = 16'($urandom);
        sent = 0;
        while (sent < n_items) begin
            period = int'(cfg_min) + $urandom_range(0, 3000);
            if (period > 65535) period = 65535;
            burst = $urandom_range(5, 40);
            for (k = 0; k < burst && sent < n_items; k++) begin
                choice = $urandom_range(0, 99);
                if (choice < 60) begin
                    jitter = $urandom_range(0, 64);
                    jitter -= 32;
                    stamp += 16'(period + jitter);
                    send_request(edge_at(stamp));
                end else if (choice < 65) begin
                    stamp += 16'($urandom_range(0, int'(cfg_min)));
                    send_request(edge_at(stamp));
                end else if (choice < 68) begin
                    stamp = 16'($urandom);
                    send_request(edge_at(stamp));
                end else begin
                    send_request(tick_item());
                end
                sent++;
            end
            if ($urandom_range(0, 5) == 0) begin
                run = $urandom_range(1, int'(cfg_timeout) + 2);
                for (k = 0; k < run && sent < n_items; k++) begin
                    send_request(tick_item());
                    sent++;
                end
            end
        end
    endtask

    task automatic test_reset_values();
        send_request(tick_item());
        send_request(edge_at(16'd0));
        send_request(edge_at(16'd300));
        send_request(tick_item());
    endtask

    task automatic test_interval_limits();
        send_request(edge_at(16'd550));
        send_request(edge_at(16'd799));
        send_request(edge_at(16'hFFFF));
        send_request(edge_at(16'd1000));
    endtask

    task automatic test_register_extremes();
        program_registers(16'd0, IDLE_TIMEOUT_RESET, FRAME_TICKS_RESET);
        send_request(edge_at(16'd1000));
        program_registers(16'hFFFF, IDLE_TIMEOUT_RESET, FRAME_TICKS_RESET);
        send_request(edge_at(16'd999));
        send_request(edge_at(16'd1000));
        program_registers(16'd100, 8'd1, 8'd1);
        send_request(tick_item());
        send_request(edge_at(16'd0));
        send_request(edge_at(16'd500));
        send_request(tick_item());
        // Out of range zero settings: clear and advance on every tick.
        program_registers(16'd100, 8'd0, 8'd0);
        send_request(edge_at(16'd900));
        send_request(edge_at(16'd1400));
        send_request(tick_item());
        send_request(edge_at(16'd2000));
        program_registers(16'd100, 8'hFF, 8'hFF);
        send_request(edge_at(16'd2600));
        send_request(edge_at(16'd3300));
        wait_for_readings();
        // Index past the register list: the write must be dropped.
        cfg_write(2'd3, 16'($urandom));
        send_request(edge_at(16'd3301));
        program_registers(MIN_INTERVAL_RESET, IDLE_TIMEOUT_RESET, FRAME_TICKS_RESET);
    endtask

    task automatic test_backpressure();
        // Hold the receiver while the sender keeps offering requests.
        tx_steady = 1'b1;
        hold_req <= hold_req + 8'd1;
        random_traffic(16);
        tx_steady = 1'b0;
        wait_for_readings();
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        random_traffic(10);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        wait_for_readings();
    endtask

    task automatic test_random_traffic();
        int p;
        program_registers(MIN_INTERVAL_RESET, IDLE_TIMEOUT_RESET, FRAME_TICKS_RESET);
        random_traffic(600);
        program_registers(16'd0, 8'hFF, 8'hFF);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        random_traffic(300);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        program_registers(16'hFFFF, 8'd1, 8'd1);
        random_traffic(200);
        for (p = 0; p < 4; p++) begin
            program_registers(16'($urandom_range(0, 4000)), 8'($urandom_range(1, 255)),
                              8'($urandom_range(1, 255)));
            random_traffic(200);
        end
        program_registers(16'd1000, 8'd0, 8'd0);
        random_traffic(100);
    endtask

    // Receiver: random stalls, an occasional long hold, and the result check.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            readings_seen++;
            if (expected_readings.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_CAP)
                    $error("result with no request pending: mean_interval %0d pulse_total %0d",
                           out_data.mean_interval, out_data.pulse_total);
            end else begin
                t_out_item want;
                want = expected_readings.pop_front();
                if (out_data.mean_interval !== want.mean_interval) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_CAP)
                        $error("mean_interval: expected %0d, got %0d",
                               want.mean_interval, out_data.mean_interval);
                end
                if (out_data.pulse_total !== want.pulse_total) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_CAP)
                        $error("pulse_total: expected %0d, got %0d",
                               want.pulse_total, out_data.pulse_total);
                end
            end
        end
        if (hold_req != hold_ack) begin
            hold_ack = hold_req;
            rx_hold_left = RX_HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            out_ready <= 1'b0;
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            if (!rx_steady) rx_stall_left = pick_gap();
        end
    end

    initial begin
        reset_tachometer();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_interval_limits();
        test_register_extremes();
        test_backpressure();
        test_random_traffic();
        wait_for_readings();
        repeat (END_SETTLE) @(posedge clk);
        if (expected_readings.size() != 0) begin
            mismatch_count++;
            $error("%0d results never arrived", expected_readings.size());
        end
        $display("Run covered %0d requests and %0d results across %0d register settings.",
                 requests_sent, readings_seen, settings_applied);
        $display("Window: %0d idle clears, %0d frame advances, %0d short intervals dropped.",
                 timeout_clears, ring_advances, glitches_rejected);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
